// ----- sv/snd_pkg.sv -----
// Package for the stepper needle step/direction driver.
// Holds the register map, configuration and state types and fixed widths.
// No dependencies; imported by every module of the block.
package snd_pkg;

	// Fixed register field widths.
	localparam int PW_W   = 16;
	localparam int JIT_W  = 8;
	localparam int IVL_W  = 20;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Distance at which the spacing reaches the fast interval.
	localparam int DIST_FULL = 100;
	localparam int DIST_W    = 7;

	// Width of the spacing comparison: product of distance and span, and 100 times slack.
	localparam int CMP_W = DIST_W + IVL_W + 3;

	// Register indexes, byte address 4*index.
	typedef enum logic [1:0] {
		REG_PULSE_WIDTH = 2'd0,
		REG_JITTER      = 2'd1,
		REG_SLOW_IVL    = 2'd2,
		REG_FAST_IVL    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [PW_W-1:0]  pulse_width_us;
		logic [JIT_W-1:0] jitter_steps;
		logic [IVL_W-1:0] slow_interval_us;
		logic [IVL_W-1:0] fast_interval_us;
	} cfg_t;

	// Control flags of the driver state.
	typedef struct packed {
		logic dir;
		logic pulse;
		logic settle;
	} flags_t;

endpackage

// ----- sv/snd_cfg.sv -----
// Configuration registers of the stepper needle driver with an APB-style port.
// Depends on snd_pkg for the register map and the cfg_t type.
module snd_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [snd_pkg::ADDR_W-1:0] paddr,
	input  logic [snd_pkg::DATA_W-1:0] pwdata,
	output logic [snd_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output snd_pkg::cfg_t             cfg
);
	import snd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register write on the access cycle of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_width_us   <= PW_W'(20);
			cfg_q.jitter_steps     <= '0;
			cfg_q.slow_interval_us <= IVL_W'(2000);
			cfg_q.fast_interval_us <= IVL_W'(500);
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_PULSE_WIDTH: cfg_q.pulse_width_us   <= pwdata[PW_W-1:0];
				REG_JITTER:      cfg_q.jitter_steps     <= pwdata[JIT_W-1:0];
				REG_SLOW_IVL:    cfg_q.slow_interval_us <= pwdata[IVL_W-1:0];
				REG_FAST_IVL:    cfg_q.fast_interval_us <= pwdata[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data, zero-extended.
	always_comb begin
		unique case (idx)
			REG_PULSE_WIDTH: prdata = DATA_W'(cfg_q.pulse_width_us);
			REG_JITTER:      prdata = DATA_W'(cfg_q.jitter_steps);
			REG_SLOW_IVL:    prdata = DATA_W'(cfg_q.slow_interval_us);
			REG_FAST_IVL:    prdata = DATA_W'(cfg_q.fast_interval_us);
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- sv/snd_core.sv -----
// Step rule of the stepper needle driver: next state for one service call.
// Purely combinational; depends on snd_pkg for cfg_t and flags_t.
module snd_core #(
	parameter int POS_BITS  = 16,
	parameter int TIME_BITS = 32
) (
	input  snd_pkg::cfg_t          cfg,
	input  snd_pkg::flags_t        flags,
	input  logic [POS_BITS-1:0]    pos,
	input  logic [TIME_BITS-1:0]   last_time,
	input  logic [POS_BITS-1:0]    target,
	input  logic [TIME_BITS-1:0]   now,
	output snd_pkg::flags_t        flags_nxt,
	output logic [POS_BITS-1:0]    pos_nxt,
	output logic [TIME_BITS-1:0]   last_time_nxt,
	output logic                   started
);
	import snd_pkg::*;

	logic signed [POS_BITS:0]      delta;
	logic [POS_BITS:0]             abs_dist;
	logic                          want_dir;
	logic [TIME_BITS-1:0]          elapsed;
	logic                          pw_ok;
	logic                          dist_ok;
	logic [DIST_W-1:0]             d_clamp;
	logic [TIME_BITS+IVL_W:0]      e_wide;
	logic [IVL_W:0]                e_sat;
	logic signed [IVL_W+1:0]       slack;
	logic signed [CMP_W-1:0]       slack_ext;
	logic signed [CMP_W-1:0]       slack_x100;
	logic signed [IVL_W:0]         span;
	logic signed [DIST_W+IVL_W+1:0] prod;
	logic signed [CMP_W-1:0]       prod_ext;
	logic                          time_ok;

	// Signed distance to the target and the direction it asks for.
	assign delta    = $signed({target[POS_BITS-1], target}) - $signed({pos[POS_BITS-1], pos});
	assign want_dir = !delta[POS_BITS] && (delta != '0);
	assign abs_dist = delta[POS_BITS] ? (POS_BITS+1)'(-delta) : (POS_BITS+1)'(delta);

	// Deadband, bypassed when the target is zero.
	assign dist_ok = (abs_dist > {{(POS_BITS+1-JIT_W){1'b0}}, cfg.jitter_steps}) ||
		(target == '0);
	assign d_clamp = (abs_dist > (POS_BITS+1)'(DIST_FULL)) ? DIST_W'(DIST_FULL) :
		abs_dist[DIST_W-1:0];

	// Elapsed time, wrapping at the timestamp width.
	assign elapsed = now - last_time;
	assign pw_ok   = elapsed >= TIME_BITS'(cfg.pulse_width_us);

	// The spacing always lies below 2^IVL_W, so saturate elapsed there.
	assign e_wide = {{(IVL_W+1){1'b0}}, elapsed};
	assign e_sat  = (|(e_wide >> IVL_W)) ? {1'b1, {IVL_W{1'b0}}} : {1'b0, e_wide[IVL_W-1:0]};

	// elapsed >= slow + trunc(d*span/100) is checked as slack = elapsed - slow
	// against d*span, scaling slack by 100 with shifts instead of dividing.
	assign slack      = $signed({1'b0, e_sat}) - $signed({2'b00, cfg.slow_interval_us});
	assign slack_ext  = CMP_W'(slack);
	assign slack_x100 = (slack_ext <<< 6) + (slack_ext <<< 5) + (slack_ext <<< 2);
	assign span       = $signed({1'b0, cfg.fast_interval_us}) - $signed({1'b0, cfg.slow_interval_us});
	assign prod       = $signed({1'b0, d_clamp}) * span;
	assign prod_ext   = CMP_W'(prod);

	// Truncation toward zero rounds a negative quotient up and a positive one down.
	always_comb begin
		if (prod_ext[CMP_W-1]) begin
			time_ok = slack_x100 >= prod_ext;
		end else begin
			time_ok = slack_x100 > (prod_ext - CMP_W'(DIST_FULL));
		end
	end

	// Priority of the step rule: direction fix, end of pulse, end of settle, new step.
	always_comb begin
		flags_nxt     = flags;
		pos_nxt       = pos;
		last_time_nxt = last_time;
		started       = 1'b0;
		if (want_dir != flags.dir) begin
			flags_nxt.dir    = want_dir;
			flags_nxt.settle = 1'b1;
			last_time_nxt    = now;
		end else if (flags.pulse && pw_ok) begin
			flags_nxt.pulse = 1'b0;
		end else if (flags.settle && pw_ok) begin
			flags_nxt.settle = 1'b0;
		end else if (!flags.pulse && !flags.settle && (delta != '0) && dist_ok && time_ok) begin
			flags_nxt.pulse = 1'b1;
			last_time_nxt   = now;
			pos_nxt         = delta[POS_BITS] ? pos - 1'b1 : pos + 1'b1;
			started         = 1'b1;
		end
	end

endmodule

// ----- sv/stepper_needle_step_dir_driver_top.sv -----
// Top level of the stepper needle step/direction driver.
// Depends on snd_pkg, snd_cfg (register port) and snd_core (step rule).
//
// Usage: each transfer on the slave stream is one service call carrying a
// target needle position and a free-running microsecond timestamp. For every
// call the master stream delivers exactly one result: step pulse level,
// direction, position after the call and a flag that marks a new step.
// The call is held in an input register; the step rule runs as one pass of
// combinational logic from that register into the result register, and the
// driver state is updated in the same cycle, so calls may follow each other
// in every cycle while the receiver takes the results.
// A call passes the input register and then the result register before its
// result appears on m_tdata. Throughput: one call per cycle while m_tready
// is high, set by the single state update of the step rule.
// When the receiver holds m_tready low the result stays in its register and
// one more call waits in the input register; s_tready then drops.
// Reset clears both stream stages, sets position to zero, direction to
// clockwise, pulse and settle inactive and the last event time to zero; the
// registers take their default values. The user must write registers over
// the APB port only while no call is in flight; the block does not enforce it.
module stepper_needle_step_dir_driver_top #(
	parameter int POS_BITS  = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [snd_pkg::ADDR_W-1:0]  paddr,
	input  logic [snd_pkg::DATA_W-1:0]  pwdata,
	output logic [snd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// Service call stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// From bit 0: target_pos (POS_BITS, signed), now_us (TIME_BITS), zero fill.
	input  logic [((POS_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
	// Result stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// From bit 0: step_pulse, direction, position (POS_BITS, signed), step_started, zero fill.
	output logic [((POS_BITS+3+7)/8)*8-1:0] m_tdata
);
	import snd_pkg::*;

	localparam int OUT_W = ((POS_BITS + 3 + 7) / 8) * 8;

	cfg_t                 cfg;
	flags_t               flags_q;
	flags_t               flags_nxt;
	logic [POS_BITS-1:0]  pos_q;
	logic [POS_BITS-1:0]  pos_nxt;
	logic [TIME_BITS-1:0] last_time_q;
	logic [TIME_BITS-1:0] last_time_nxt;
	logic                 started;

	logic                 valid_s1;
	logic [POS_BITS-1:0]  target_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 advance;

	logic                 out_valid_q;
	logic                 out_pulse_q;
	logic                 out_dir_q;
	logic [POS_BITS-1:0]  out_pos_q;
	logic                 out_started_q;

	snd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	snd_core #(
		.POS_BITS  (POS_BITS),
		.TIME_BITS (TIME_BITS)
	) u_core (
		.cfg           (cfg),
		.flags         (flags_q),
		.pos           (pos_q),
		.last_time     (last_time_q),
		.target        (target_s1),
		.now           (now_s1),
		.flags_nxt     (flags_nxt),
		.pos_nxt       (pos_nxt),
		.last_time_nxt (last_time_nxt),
		.started       (started)
	);

	// The call in the input register moves on when the result register is free.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			target_s1 <= s_tdata[POS_BITS-1:0];
			now_s1    <= s_tdata[POS_BITS+TIME_BITS-1:POS_BITS];
		end
	end

	// Driver state, updated once per call.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '{dir: 1'b1, pulse: 1'b0, settle: 1'b0};
			pos_q       <= '0;
			last_time_q <= '0;
		end else if (advance) begin
			flags_q     <= flags_nxt;
			pos_q       <= pos_nxt;
			last_time_q <= last_time_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pulse_q   <= flags_nxt.pulse;
			out_dir_q     <= flags_nxt.dir;
			out_pos_q     <= pos_nxt;
			out_started_q <= started;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_started_q, out_pos_q, out_dir_q, out_pulse_q});

	// A result that reports a new step also shows the pulse high.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_started_q |-> out_pulse_q)
		else $error("new step reported without active pulse");

	// Position moves only when a call starts a step.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && started) |=> $stable(pos_q))
		else $error("position changed without a step");

	// A waiting call is never lost or overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(now_s1) && $stable(target_s1))
		else $error("held call lost in input register");

	// Pulse and settle can only start together with a state update.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(flags_q) && $stable(last_time_q))
		else $error("driver state changed without a call");

endmodule
